[rtl/vxf_pkg.sv]
// Package for the voxel exposed-face extractor: sizes, codes, payload types and
// the cube face and corner tables.
// Has no dependencies; every other file of the block uses it.
package vxf_pkg;

   localparam int MAX_DIM     = 32;
   localparam int CRD_W       = 5;
   localparam int CFG_W       = 6;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int SIZE_W      = $clog2(MAX_DIM + 1);
   localparam int CW          = ((SIZE_W > CRD_W) ? SIZE_W : CRD_W) + 1;
   localparam int ROWS        = MAX_DIM * MAX_DIM;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int CNT_W       = 18;
   localparam int VNUM_W      = 20;
   localparam int CORNER_W    = 18;
   localparam int PACK_W      = 6;
   localparam int SIDE_W      = 3;
   localparam int NUM_FACES   = 6;
   localparam int NUM_LOOKUPS = NUM_FACES + 1;
   localparam int LK_W        = $clog2(NUM_LOOKUPS + 1);
   localparam int NUM_REGS    = 3;
   localparam int REG_W       = $clog2(NUM_REGS);
   localparam int ADDR_W      = REG_W + 2;
   localparam int DATA_W      = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EMIT  = 1'b1;

   localparam logic [REG_W-1:0] REG_SIZE_X = REG_W'(0);
   localparam logic [REG_W-1:0] REG_SIZE_Y = REG_W'(1);
   localparam logic [REG_W-1:0] REG_SIZE_Z = REG_W'(2);

   localparam logic [SIDE_W-1:0] FACE_LEFT  = SIDE_W'(0);
   localparam logic [SIDE_W-1:0] FACE_BACK  = SIDE_W'(1);
   localparam logic [SIDE_W-1:0] FACE_RIGHT = SIDE_W'(2);
   localparam logic [SIDE_W-1:0] FACE_FRONT = SIDE_W'(3);
   localparam logic [SIDE_W-1:0] FACE_UP    = SIDE_W'(4);
   localparam logic [SIDE_W-1:0] FACE_DOWN  = SIDE_W'(5);

   // Lookup zero is the voxel itself; lookup n is the neighbor behind face n-1.
   localparam logic [LK_W-1:0] LK_SELF = LK_W'(0);

   typedef struct packed {
      logic             opcode;
      logic [CRD_W-1:0] voxel_x;
      logic [CRD_W-1:0] voxel_y;
      logic [CRD_W-1:0] voxel_z;
      logic             occupied;
   } req_type;

   typedef struct packed {
      logic [SIDE_W-1:0]   face_side;
      logic [CORNER_W-1:0] corner_a;
      logic [CORNER_W-1:0] corner_b;
      logic [CORNER_W-1:0] corner_c;
      logic [CORNER_W-1:0] corner_d;
      logic [VNUM_W-1:0]   first_vertex_number;
      logic                last_face;
   } rsp_type;

   typedef struct packed {
      logic [CW-1:0] dx;
      logic [CW-1:0] dy;
      logic [CW-1:0] dz;
   } delta_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (int'(s) > MAX_DIM) begin
         r = SIZE_W'(MAX_DIM);
      end else begin
         r = SIZE_W'(s);
      end
      return r;
   endfunction

   // Step toward the neighbor of a lookup; minus one is the all-ones pattern.
   function automatic delta_type lookup_delta(input logic [LK_W-1:0] lk);
      delta_type d;
      d = '0;
      case (lk)
         LK_W'(1): d.dx = '1;
         LK_W'(2): d.dy = '1;
         LK_W'(3): d.dx = CW'(1);
         LK_W'(4): d.dy = CW'(1);
         LK_W'(5): d.dz = CW'(1);
         LK_W'(6): d.dz = '1;
         default:  d = '0;
      endcase
      return d;
   endfunction

   // Cube vertex offsets as {dx, dy, dz}.
   function automatic logic [2:0] vert_off(input logic [2:0] v);
      logic [2:0] r;
      case (v)
         3'd0:    r = 3'b000;
         3'd1:    r = 3'b100;
         3'd2:    r = 3'b110;
         3'd3:    r = 3'b010;
         3'd4:    r = 3'b001;
         3'd5:    r = 3'b101;
         3'd6:    r = 3'b111;
         3'd7:    r = 3'b011;
         default: r = 3'b000;
      endcase
      return r;
   endfunction

   // Vertex number of corner c of a face, in the fixed winding order.
   function automatic logic [2:0] face_vert(input logic [SIDE_W-1:0] f,
                                            input logic [1:0] c);
      logic [11:0] row;
      case (f)
         FACE_LEFT:  row = {3'd0, 3'd3, 3'd7, 3'd4};
         FACE_BACK:  row = {3'd0, 3'd1, 3'd5, 3'd4};
         FACE_RIGHT: row = {3'd1, 3'd2, 3'd6, 3'd5};
         FACE_FRONT: row = {3'd3, 3'd2, 3'd6, 3'd7};
         FACE_UP:    row = {3'd4, 3'd5, 3'd6, 3'd7};
         FACE_DOWN:  row = {3'd0, 3'd1, 3'd2, 3'd3};
         default:    row = '0;
      endcase
      return row[(3 - c) * 3 +: 3];
   endfunction

   function automatic logic [CORNER_W-1:0] face_corner(input logic [CRD_W-1:0] x,
                                                       input logic [CRD_W-1:0] y,
                                                       input logic [CRD_W-1:0] z,
                                                       input logic [SIDE_W-1:0] f,
                                                       input logic [1:0] c);
      logic [2:0]        off;
      logic [PACK_W-1:0] px;
      logic [PACK_W-1:0] py;
      logic [PACK_W-1:0] pz;
      off = vert_off(face_vert(f, c));
      px  = PACK_W'(x) + PACK_W'(off[2]);
      py  = PACK_W'(y) + PACK_W'(off[1]);
      pz  = PACK_W'(z) + PACK_W'(off[0]);
      return {px, py, pz};
   endfunction

endpackage

[rtl/voxel_exposed_face_extractor_unit.sv]
// Top level of the voxel exposed-face extractor: occupancy row memory, lookup
// unit, sequencer, result register and size registers.
// Depends on vxf_pkg.
//
//   Port group   Direction   Handshake            Carries
//   req_*        in          req_valid/req_stall  vxf_pkg::req_type transaction
//   rsp_*        out         rsp_valid/rsp_stall  vxf_pkg::rsp_type transaction
//   csr_*        in/out      APB, pready high     size_x, size_y, size_z
//
// A write transaction goes through accept, row read and row write back.
// An emit transaction of an occupied voxel goes through accept, a scan in which the
// shared lookup unit reads the voxel and its six neighbors from the single read port
// of the row memory, then an output phase that steps through the six faces in order.
// An emit of an empty voxel or of one outside the grid ends after the lookups.
// After reset a clearing pass zeroes all MAX_DIM*MAX_DIM rows (1024) of the memory one
// row a cycle, while req_stall stays high; size registers are written as ever.
// A stalled result holds the sequencer only when the next face needs the slot.
module voxel_exposed_face_extractor_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  vxf_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output vxf_pkg::rsp_type             rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vxf_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [vxf_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [vxf_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WR_RD = 3'd2;
   localparam logic [2:0] S_WR_WR = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam int MAX_ROW_BITS = vxf_pkg::MAX_DIM;

   logic [2:0]                    state_ff, state_in;
   logic [vxf_pkg::ROW_W-1:0]     clr_ff, clr_in;
   vxf_pkg::req_type              item_ff, item_in;
   logic [vxf_pkg::LK_W-1:0]      scan_ff, scan_in;
   logic [vxf_pkg::SIDE_W-1:0]    face_ff, face_in;
   logic [vxf_pkg::NUM_FACES-1:0] mask_ff, mask_in;
   logic                          self_ff, self_in;
   logic                          lk_ok_ff, lk_ok_in;
   logic [vxf_pkg::IDX_W-1:0]     lk_bit_ff, lk_bit_in;
   logic [vxf_pkg::ROW_W-1:0]     lk_addr_ff, lk_addr_in;
   logic [vxf_pkg::CNT_W-1:0]     face_count_ff, face_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   vxf_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [vxf_pkg::CFG_W-1:0]     size_x_ff, size_x_in;
   logic [vxf_pkg::CFG_W-1:0]     size_y_ff, size_y_in;
   logic [vxf_pkg::CFG_W-1:0]     size_z_ff, size_z_in;

   logic [MAX_ROW_BITS-1:0]       mem [vxf_pkg::ROWS];
   logic [MAX_ROW_BITS-1:0]       rd_data_ff;
   logic [MAX_ROW_BITS-1:0]       row_mod;
   logic                          mem_we;
   logic [vxf_pkg::ROW_W-1:0]     mem_waddr;
   logic [MAX_ROW_BITS-1:0]       mem_wdata;

   logic [vxf_pkg::LK_W-1:0]      lk_sel;
   vxf_pkg::delta_type            delta;
   logic [vxf_pkg::CW-1:0]        nx, ny, nz;
   logic [vxf_pkg::SIZE_W-1:0]    eff_x, eff_y, eff_z;
   logic                          lk_ok;
   logic [vxf_pkg::ROW_W-1:0]     lk_addr;
   logic                          req_accept;
   logic                          csr_write;
   logic                          slot_free;
   logic                          occ;
   logic                          later;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   assign eff_x = vxf_pkg::eff_size(size_x_ff);
   assign eff_y = vxf_pkg::eff_size(size_y_ff);
   assign eff_z = vxf_pkg::eff_size(size_z_ff);

   // Shared lookup unit: neighbor coordinates, bounds check and row address.
   always_comb begin
      lk_sel  = (state_ff == S_SCAN) ? scan_ff : vxf_pkg::LK_SELF;
      delta   = vxf_pkg::lookup_delta(lk_sel);
      nx      = vxf_pkg::CW'(item_ff.voxel_x) + delta.dx;
      ny      = vxf_pkg::CW'(item_ff.voxel_y) + delta.dy;
      nz      = vxf_pkg::CW'(item_ff.voxel_z) + delta.dz;
      lk_ok   = (nx < vxf_pkg::CW'(eff_x)) && (ny < vxf_pkg::CW'(eff_y))
                && (nz < vxf_pkg::CW'(eff_z));
      lk_addr = lk_ok ? vxf_pkg::ROW_W'(nx[vxf_pkg::IDX_W-1:0] * vxf_pkg::MAX_DIM
                                        + ny[vxf_pkg::IDX_W-1:0])
                      : '0;
   end

   always_comb begin
      row_mod            = rd_data_ff;
      row_mod[lk_bit_ff] = item_ff.occupied;
      mem_we             = (state_ff == S_CLEAR) || ((state_ff == S_WR_WR) && lk_ok_ff);
      mem_waddr          = (state_ff == S_CLEAR) ? clr_ff : lk_addr_ff;
      mem_wdata          = (state_ff == S_CLEAR) ? '0 : row_mod;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[lk_addr];
   end

   assign occ = lk_ok_ff && rd_data_ff[lk_bit_ff];

   always_comb begin
      later = 1'b0;
      for (int i = 0; i < vxf_pkg::NUM_FACES; i++) begin
         if ((vxf_pkg::SIDE_W'(i) > face_ff) && mask_ff[i]) begin
            later = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      item_in       = item_ff;
      scan_in       = scan_ff;
      face_in       = face_ff;
      mask_in       = mask_ff;
      self_in       = self_ff;
      lk_ok_in      = lk_ok_ff;
      lk_bit_in     = lk_bit_ff;
      lk_addr_in    = lk_addr_ff;
      face_count_in = face_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + vxf_pkg::ROW_W'(1);
            if (clr_ff == vxf_pkg::ROW_W'(vxf_pkg::ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               item_in = req_data;
               scan_in = '0;
               if (req_data.opcode == vxf_pkg::OP_WRITE) begin
                  face_count_in = '0;
                  state_in      = S_WR_RD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_WR_RD: begin
            lk_ok_in   = lk_ok;
            lk_bit_in  = nz[vxf_pkg::IDX_W-1:0];
            lk_addr_in = lk_addr;
            state_in   = S_WR_WR;
         end
         S_WR_WR: begin
            state_in = S_IDLE;
         end
         S_SCAN: begin
            lk_ok_in  = lk_ok;
            lk_bit_in = nz[vxf_pkg::IDX_W-1:0];
            scan_in   = scan_ff + vxf_pkg::LK_W'(1);
            if (scan_ff == vxf_pkg::LK_W'(1)) begin
               self_in = occ;
            end else if (scan_ff != vxf_pkg::LK_SELF) begin
               mask_in[vxf_pkg::SIDE_W'(scan_ff - vxf_pkg::LK_W'(2))] = !occ;
            end
            if (scan_ff == vxf_pkg::LK_W'(vxf_pkg::NUM_LOOKUPS)) begin
               face_in  = '0;
               state_in = self_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (!mask_ff[face_ff] || slot_free) begin
               if (mask_ff[face_ff]) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.face_side = face_ff;
                  rsp_data_in.corner_a  = vxf_pkg::face_corner(item_ff.voxel_x,
                     item_ff.voxel_y, item_ff.voxel_z, face_ff, 2'd0);
                  rsp_data_in.corner_b  = vxf_pkg::face_corner(item_ff.voxel_x,
                     item_ff.voxel_y, item_ff.voxel_z, face_ff, 2'd1);
                  rsp_data_in.corner_c  = vxf_pkg::face_corner(item_ff.voxel_x,
                     item_ff.voxel_y, item_ff.voxel_z, face_ff, 2'd2);
                  rsp_data_in.corner_d  = vxf_pkg::face_corner(item_ff.voxel_x,
                     item_ff.voxel_y, item_ff.voxel_z, face_ff, 2'd3);
                  rsp_data_in.first_vertex_number = {face_count_ff, 2'b01};
                  rsp_data_in.last_face = !later;
                  face_count_in         = face_count_ff + vxf_pkg::CNT_W'(1);
               end
               if (face_ff == vxf_pkg::SIDE_W'(vxf_pkg::NUM_FACES - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  face_in = face_ff + vxf_pkg::SIDE_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_write) begin
         case (csr_paddr[vxf_pkg::ADDR_W-1:2])
            vxf_pkg::REG_SIZE_X: size_x_in = csr_pwdata[vxf_pkg::CFG_W-1:0];
            vxf_pkg::REG_SIZE_Y: size_y_in = csr_pwdata[vxf_pkg::CFG_W-1:0];
            vxf_pkg::REG_SIZE_Z: size_z_in = csr_pwdata[vxf_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[vxf_pkg::ADDR_W-1:2])
         vxf_pkg::REG_SIZE_X: csr_prdata = vxf_pkg::DATA_W'(size_x_ff);
         vxf_pkg::REG_SIZE_Y: csr_prdata = vxf_pkg::DATA_W'(size_y_ff);
         vxf_pkg::REG_SIZE_Z: csr_prdata = vxf_pkg::DATA_W'(size_z_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         scan_ff       <= '0;
         face_ff       <= '0;
         mask_ff       <= '0;
         self_ff       <= 1'b0;
         lk_ok_ff      <= 1'b0;
         face_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         size_x_ff     <= vxf_pkg::CFG_W'(32);
         size_y_ff     <= vxf_pkg::CFG_W'(32);
         size_z_ff     <= vxf_pkg::CFG_W'(32);
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         scan_ff       <= scan_in;
         face_ff       <= face_in;
         mask_ff       <= mask_in;
         self_ff       <= self_in;
         lk_ok_ff      <= lk_ok_in;
         face_count_ff <= face_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         size_x_ff     <= size_x_in;
         size_y_ff     <= size_y_in;
         size_z_ff     <= size_z_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      lk_bit_ff   <= lk_bit_in;
      lk_addr_ff  <= lk_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A new result only ever comes out of the face output phase.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result raised outside the face output phase");

   // A write transaction restarts the vertex numbering.
   a_write_clears_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.opcode == vxf_pkg::OP_WRITE)) |=> (face_count_ff == '0))
      else $error("face counter not cleared by a write");

   // The face index stays on a real face while results are given.
   a_face_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (face_ff < vxf_pkg::SIDE_W'(vxf_pkg::NUM_FACES)))
      else $error("face index out of range");

   // A row is written back only after its read in the previous cycle.
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR_WR) |-> ($past(state_ff) == S_WR_RD))
      else $error("row write back without a preceding read");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for voxel_exposed_face_extractor_unit. It writes and emits voxels
// under several grid sizes and idle patterns, predicts every exposed face on its own, and
// compares each result transaction field by field. Depends on vxf_pkg and the unit.
module testbench;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int TAIL_CYCLES = 40;
   localparam int REPORT_CAP  = 200;
   localparam int PHASE_ITEMS = 86;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   vxf_pkg::req_type             req_data    = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   vxf_pkg::rsp_type             rsp_data;
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [vxf_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [vxf_pkg::DATA_W-1:0]   csr_pwdata  = '0;
   logic [vxf_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   vxf_pkg::req_type             pending_items[$];
   vxf_pkg::rsp_type             expected_faces[$];
   bit                           occ_map [vxf_pkg::MAX_DIM * vxf_pkg::MAX_DIM
                                          * vxf_pkg::MAX_DIM];
   logic [vxf_pkg::CNT_W-1:0]    face_count = '0;
   logic [vxf_pkg::CFG_W-1:0]    extent_x   = vxf_pkg::CFG_W'(vxf_pkg::MAX_DIM);
   logic [vxf_pkg::CFG_W-1:0]    extent_y   = vxf_pkg::CFG_W'(vxf_pkg::MAX_DIM);
   logic [vxf_pkg::CFG_W-1:0]    extent_z   = vxf_pkg::CFG_W'(vxf_pkg::MAX_DIM);

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_queued   = 0;
   int items_accepted = 0;
   int writes_seen    = 0;
   int emits_seen     = 0;
   int faces_checked  = 0;
   int settings_count = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   voxel_exposed_face_extractor_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int grid_extent(input logic [vxf_pkg::CFG_W-1:0] s);
      if (s == '0) return 1;
      if (int'(s) > vxf_pkg::MAX_DIM) return vxf_pkg::MAX_DIM;
      return int'(s);
   endfunction

   function automatic bit voxel_solid(input int x, input int y, input int z);
      if (x < 0 || y < 0 || z < 0) return 1'b0;
      if (x >= grid_extent(extent_x) || y >= grid_extent(extent_y)
          || z >= grid_extent(extent_z)) return 1'b0;
      return occ_map[(x * vxf_pkg::MAX_DIM + y) * vxf_pkg::MAX_DIM + z];
   endfunction

   function automatic bit neighbor_solid(input int x, input int y, input int z,
                                         input logic [vxf_pkg::SIDE_W-1:0] side);
      bit r;
      case (side)
         vxf_pkg::FACE_LEFT:  r = voxel_solid(x - 1, y, z);
         vxf_pkg::FACE_BACK:  r = voxel_solid(x, y - 1, z);
         vxf_pkg::FACE_RIGHT: r = voxel_solid(x + 1, y, z);
         vxf_pkg::FACE_FRONT: r = voxel_solid(x, y + 1, z);
         vxf_pkg::FACE_UP:    r = voxel_solid(x, y, z + 1);
         vxf_pkg::FACE_DOWN:  r = voxel_solid(x, y, z - 1);
         default:             r = 1'b1;
      endcase
      return r;
   endfunction

   // Corner offsets {dx, dy, dz} of a face in winding order, first corner in the top bits.
   function automatic logic [11:0] face_offsets(input logic [vxf_pkg::SIDE_W-1:0] side);
      logic [11:0] r;
      case (side)
         vxf_pkg::FACE_LEFT:  r = {3'b000, 3'b010, 3'b011, 3'b001};
         vxf_pkg::FACE_BACK:  r = {3'b000, 3'b100, 3'b101, 3'b001};
         vxf_pkg::FACE_RIGHT: r = {3'b100, 3'b110, 3'b111, 3'b101};
         vxf_pkg::FACE_FRONT: r = {3'b010, 3'b110, 3'b111, 3'b011};
         vxf_pkg::FACE_UP:    r = {3'b001, 3'b101, 3'b111, 3'b011};
         vxf_pkg::FACE_DOWN:  r = {3'b000, 3'b100, 3'b110, 3'b010};
         default:             r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [vxf_pkg::CORNER_W-1:0] corner_code(input int x, input int y,
                                                                input int z,
                                                                input logic [2:0] off);
      logic [vxf_pkg::PACK_W-1:0] px;
      logic [vxf_pkg::PACK_W-1:0] py;
      logic [vxf_pkg::PACK_W-1:0] pz;
      px = vxf_pkg::PACK_W'(x + int'(off[2]));
      py = vxf_pkg::PACK_W'(y + int'(off[1]));
      pz = vxf_pkg::PACK_W'(z + int'(off[0]));
      return {px, py, pz};
   endfunction

   task automatic predict_faces(input vxf_pkg::req_type t);
      int                            x;
      int                            y;
      int                            z;
      int                            last_side;
      logic [vxf_pkg::NUM_FACES-1:0] open_mask;
      logic [11:0]                   offs;
      vxf_pkg::rsp_type              face;
      x = int'(t.voxel_x);
      y = int'(t.voxel_y);
      z = int'(t.voxel_z);
      if (t.opcode == vxf_pkg::OP_WRITE) begin
         writes_seen++;
         if (x < grid_extent(extent_x) && y < grid_extent(extent_y)
             && z < grid_extent(extent_z)) begin
            occ_map[(x * vxf_pkg::MAX_DIM + y) * vxf_pkg::MAX_DIM + z] = t.occupied;
         end
         face_count = '0;
      end else begin
         emits_seen++;
         open_mask = '0;
         last_side = -1;
         if (voxel_solid(x, y, z)) begin
            for (int f = 0; f < vxf_pkg::NUM_FACES; f++) begin
               open_mask[f] = !neighbor_solid(x, y, z, vxf_pkg::SIDE_W'(f));
               if (open_mask[f]) last_side = f;
            end
         end
         for (int f = 0; f < vxf_pkg::NUM_FACES; f++) begin
            if (open_mask[f]) begin
               offs                     = face_offsets(vxf_pkg::SIDE_W'(f));
               face.face_side           = vxf_pkg::SIDE_W'(f);
               face.corner_a            = corner_code(x, y, z, offs[11:9]);
               face.corner_b            = corner_code(x, y, z, offs[8:6]);
               face.corner_c            = corner_code(x, y, z, offs[5:3]);
               face.corner_d            = corner_code(x, y, z, offs[2:0]);
               face.first_vertex_number = {face_count, 2'b01};
               face.last_face           = (f == last_side);
               face_count               = face_count + vxf_pkg::CNT_W'(1);
               expected_faces.push_back(face);
            end
         end
      end
   endtask

   always @(posedge clock) begin : driver
      logic             next_valid;
      vxf_pkg::req_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_item  = req_data;
         if (req_valid && !req_stall) begin
            predict_faces(req_data);
            items_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() != 0
             && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item  = pending_items.pop_front();
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
         req_data  <= next_item;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= REPORT_CAP) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      vxf_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_faces.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_CAP) begin
                  $error("Unexpected result transaction with face_side %0d",
                         rsp_data.face_side);
               end
            end else begin
               want = expected_faces.pop_front();
               faces_checked++;
               if (rsp_data.face_side !== want.face_side)
                  report_mismatch("face_side", 32'(want.face_side),
                                  32'(rsp_data.face_side));
               if (rsp_data.corner_a !== want.corner_a)
                  report_mismatch("corner_a", 32'(want.corner_a), 32'(rsp_data.corner_a));
               if (rsp_data.corner_b !== want.corner_b)
                  report_mismatch("corner_b", 32'(want.corner_b), 32'(rsp_data.corner_b));
               if (rsp_data.corner_c !== want.corner_c)
                  report_mismatch("corner_c", 32'(want.corner_c), 32'(rsp_data.corner_c));
               if (rsp_data.corner_d !== want.corner_d)
                  report_mismatch("corner_d", 32'(want.corner_d), 32'(rsp_data.corner_d));
               if (rsp_data.first_vertex_number !== want.first_vertex_number)
                  report_mismatch("first_vertex_number", 32'(want.first_vertex_number),
                                  32'(rsp_data.first_vertex_number));
               if (rsp_data.last_face !== want.last_face)
                  report_mismatch("last_face", 32'(want.last_face),
                                  32'(rsp_data.last_face));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic queue_item(input logic op, input int x, input int y, input int z,
                             input logic occ);
      vxf_pkg::req_type t;
      t.opcode   = op;
      t.voxel_x  = vxf_pkg::CRD_W'(x);
      t.voxel_y  = vxf_pkg::CRD_W'(y);
      t.voxel_z  = vxf_pkg::CRD_W'(z);
      t.occupied = occ;
      pending_items.push_back(t);
      items_queued++;
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || expected_faces.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [vxf_pkg::REG_W-1:0] index,
                            input logic [vxf_pkg::CFG_W-1:0] value);
      logic [vxf_pkg::DATA_W-1:0] word;
      word                     = $urandom;
      word[vxf_pkg::CFG_W-1:0] = value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         vxf_pkg::REG_SIZE_X: extent_x = value;
         vxf_pkg::REG_SIZE_Y: extent_y = value;
         vxf_pkg::REG_SIZE_Z: extent_z = value;
         default:             ;
      endcase
   endtask

   task automatic set_extents(input int sx, input int sy, input int sz);
      csr_write(vxf_pkg::REG_SIZE_X, vxf_pkg::CFG_W'(sx));
      csr_write(vxf_pkg::REG_SIZE_Y, vxf_pkg::CFG_W'(sy));
      csr_write(vxf_pkg::REG_SIZE_Z, vxf_pkg::CFG_W'(sz));
      settings_count++;
   endtask

   function automatic int random_extent();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, (1 << vxf_pkg::CFG_W) - 1);
      return $urandom_range(1, 6);
   endfunction

   // Most coordinates fall in a small window so that neighbors are often occupied.
   task automatic random_phase(input int send_pct, input int recv_pct);
      int      ext [3];
      int      win [3];
      int      base [3];
      int      c [3];
      logic    op;
      logic    occ;
      int      last_write [3];
      wait_idle();
      set_extents(random_extent(), random_extent(), random_extent());
      ext[0] = grid_extent(extent_x);
      ext[1] = grid_extent(extent_y);
      ext[2] = grid_extent(extent_z);
      for (int a = 0; a < 3; a++) begin
         win[a]        = (ext[a] < 6) ? ext[a] : 6;
         base[a]       = $urandom_range(0, ext[a] - win[a]);
         last_write[a] = base[a];
      end
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (PHASE_ITEMS) begin
         op  = ($urandom_range(0, 99) < 45) ? vxf_pkg::OP_WRITE : vxf_pkg::OP_EMIT;
         occ = ($urandom_range(0, 99) < 80);
         for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 99) < 15)
               c[a] = $urandom_range(0, (1 << vxf_pkg::CRD_W) - 1);
            else c[a] = base[a] + $urandom_range(0, win[a] - 1);
         end
         if (op == vxf_pkg::OP_EMIT && $urandom_range(0, 99) < 30) c = last_write;
         if (op == vxf_pkg::OP_WRITE) last_write = c;
         queue_item(op, c[0], c[1], c[2], occ);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at full grid size: lone cubes, the far corner, shared faces.
      set_extents(vxf_pkg::MAX_DIM, vxf_pkg::MAX_DIM, vxf_pkg::MAX_DIM);
      queue_item(vxf_pkg::OP_WRITE, 0, 0, 0, 1'b1);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_WRITE, 31, 31, 31, 1'b1);
      queue_item(vxf_pkg::OP_EMIT, 31, 31, 31, 1'b1);
      queue_item(vxf_pkg::OP_WRITE, 1, 0, 0, 1'b1);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 1, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 5, 5, 5, 1'b1);
      queue_item(vxf_pkg::OP_WRITE, 0, 0, 1, 1'b1);
      queue_item(vxf_pkg::OP_WRITE, 0, 1, 0, 1'b1);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_WRITE, 1, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_WRITE, 4, 2, 2, 1'b1);
      queue_item(vxf_pkg::OP_WRITE, 3, 2, 2, 1'b1);

      // Shrunk grid: kept bits outside it read as empty, outside writes only clear the count.
      wait_idle();
      set_extents(4, 4, 4);
      queue_item(vxf_pkg::OP_EMIT, 3, 2, 2, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 4, 2, 2, 1'b0);
      queue_item(vxf_pkg::OP_WRITE, 10, 1, 1, 1'b1);
      queue_item(vxf_pkg::OP_EMIT, 3, 2, 2, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 10, 1, 1, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 31, 31, 31, 1'b0);

      // A zero extent acts as one voxel.
      wait_idle();
      set_extents(0, 0, 0);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_WRITE, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);
      queue_item(vxf_pkg::OP_WRITE, 0, 0, 0, 1'b1);

      // Extents above the maximum are clamped to it.
      wait_idle();
      set_extents((1 << vxf_pkg::CFG_W) - 1, 40, vxf_pkg::MAX_DIM + 1);
      queue_item(vxf_pkg::OP_EMIT, 31, 31, 31, 1'b0);
      queue_item(vxf_pkg::OP_EMIT, 0, 0, 0, 1'b0);

      random_phase(0, 0);
      random_phase(72, 0);
      random_phase(0, 72);
      random_phase(30, 30);

      wait_idle();
      $display("Covered %0d transactions (%0d writes, %0d emits) under %0d grid settings,",
               items_accepted, writes_seen, emits_seen, settings_count);
      $display("with %0d face results checked across four idle patterns.", faces_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_faces.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[voxel_exposed_face_extractor_unit.f]
rtl/vxf_pkg.sv
rtl/voxel_exposed_face_extractor_unit.sv
dv/testbench.sv
